// ----- src/ipb_pkg.sv -----
// Shared widths and defaults for the indexed palette builder.
package ipb_pkg;

  localparam int RGB_W              = 24;
  localparam int IDX_OUT_W          = 8;
  localparam int COUNT_W            = 9;
  localparam int BITS_W             = 4;
  localparam int MAX_INDEX_BITS_DEF = 8;
  localparam int RESET_WIDTH_BITS   = 1;

endpackage

// ----- src/ipb_in_if.sv -----
// Pixel channel: valid/ready handshake with colour and last-pixel mark.
interface ipb_in_if
  import ipb_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [RGB_W-1:0] pixel_rgb;
  logic             last_pixel;

  modport source (output valid, output pixel_rgb, output last_pixel, input ready);
  modport sink   (input valid, input pixel_rgb, input last_pixel, output ready);
endinterface

// ----- src/ipb_out_if.sv -----
// Result channel: palette index and palette status per pixel.
interface ipb_out_if
  import ipb_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [IDX_OUT_W-1:0] palette_index;
  logic                 is_new_color;
  logic [COUNT_W-1:0]   color_count;
  logic [BITS_W-1:0]    index_bits;
  logic                 too_many_colors;
  logic                 image_done;

  modport source (output valid, output palette_index, output is_new_color,
                  output color_count, output index_bits, output too_many_colors,
                  output image_done, input ready);
  modport sink   (input valid, input palette_index, input is_new_color,
                  input color_count, input index_bits, input too_many_colors,
                  input image_done, output ready);
endinterface

// ----- src/indexed_palette_builder.sv -----
// Top level: palette builder built from a row of compare-and-store cells.
//
//   channel  dir  handshake      payload
//   in_chan  in   valid/ready    pixel_rgb[23:0], last_pixel
//   out_chan out  valid/ready    palette_index[7:0], is_new_color, color_count[8:0],
//                                index_bits[3:0], too_many_colors, image_done
//
// For each pixel, the edge that takes it registers every cell's compare; the lookup
// step then encodes the hit, appends a new colour and loads the result.
// A further pixel is taken once the result is loaded; a full output register
// holds the lookup step until out_chan is ready.
// rst_n (synchronous) empties the palette; colour storage itself is not cleared.
module indexed_palette_builder
  import ipb_pkg::*;
#(
  parameter int MAX_INDEX_BITS = MAX_INDEX_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  ipb_in_if.sink    in_chan,
  ipb_out_if.source out_chan
);
  localparam int                 DEPTH    = 1 << MAX_INDEX_BITS;
  localparam logic [COUNT_W-1:0] CAP      = COUNT_W'(DEPTH);
  localparam logic [BITS_W-1:0]  MAX_BITS = BITS_W'(MAX_INDEX_BITS);
  localparam logic [BITS_W-1:0]  RST_BITS = BITS_W'(RESET_WIDTH_BITS);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_LOOK = 2'b10
  } state_t;

  state_t               state_r, state_nxt;
  logic [RGB_W-1:0]     pixel_r;
  logic                 last_r;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [BITS_W-1:0]    width_r, width_nxt;
  logic                 ovf_r, ovf_nxt;

  logic                 out_valid_r;
  logic [IDX_OUT_W-1:0] out_index_r, out_index_nxt;
  logic                 out_new_r, out_new_nxt;
  logic [COUNT_W-1:0]   out_count_r;
  logic [BITS_W-1:0]    out_bits_r;
  logic                 out_ovf_r;
  logic                 out_done_r;

  logic                 accept;
  logic                 resolve;
  logic                 fits;
  logic                 wr_en;
  logic [COUNT_W-1:0]   slots;
  logic [DEPTH-1:0]     match;
  logic [DEPTH:0]       occ_chain;
  logic                 hit;
  logic [MAX_INDEX_BITS-1:0] hit_index;

  assign in_chan.ready = (state_r == S_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign resolve       = (state_r == S_LOOK) && (!out_valid_r || out_chan.ready);

  // row of cells; each hands its occupancy to the next
  assign occ_chain[0] = 1'b1;
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    ipb_cell #(.SLOT(g)) u_cell (
      .clk      (clk),
      .cmp_en   (accept),
      .cmp_key  (in_chan.pixel_rgb),
      .wr_en    (wr_en),
      .wr_key   (pixel_r),
      .count    (count_r),
      .prev_occ (occ_chain[g]),
      .occ      (occ_chain[g+1]),
      .match_r  (match[g])
    );
  end

  ipb_encoder #(.DEPTH(DEPTH), .IDX_W(MAX_INDEX_BITS)) u_enc (
    .match (match),
    .hit   (hit),
    .index (hit_index)
  );

  // lookup outcome: found, appended, or dropped as overflow
  always_comb begin
    slots         = COUNT_W'(1) << width_r;
    fits          = 1'b1;
    width_nxt     = width_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    out_index_nxt = IDX_OUT_W'(hit_index);
    out_new_nxt   = 1'b0;
    if (!hit) begin
      if (count_r >= slots) begin
        if (width_r < MAX_BITS) begin
          width_nxt = width_r + BITS_W'(1);
        end else begin
          fits = 1'b0;
        end
      end
      if (count_r >= CAP) begin
        fits = 1'b0;
      end
      if (fits) begin
        out_index_nxt = IDX_OUT_W'(count_r);
        count_nxt     = count_r + COUNT_W'(1);
        out_new_nxt   = 1'b1;
      end else begin
        ovf_nxt       = 1'b1;
        out_index_nxt = '0;
      end
    end
  end

  assign wr_en = resolve && !hit && fits;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_LOOK;
      S_LOOK: if (resolve) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and palette status
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      width_r     <= RST_BITS;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (resolve) begin
        out_valid_r <= 1'b1;
        if (last_r) begin
          count_r <= '0;
          width_r <= RST_BITS;
          ovf_r   <= 1'b0;
        end else begin
          count_r <= count_nxt;
          width_r <= width_nxt;
          ovf_r   <= ovf_nxt;
        end
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // pixel holding and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pixel_r <= in_chan.pixel_rgb;
      last_r  <= in_chan.last_pixel;
    end
    if (resolve) begin
      out_index_r <= out_index_nxt;
      out_new_r   <= out_new_nxt;
      out_count_r <= count_nxt;
      out_bits_r  <= width_nxt;
      out_ovf_r   <= ovf_nxt;
      out_done_r  <= last_r;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.palette_index   = out_index_r;
  assign out_chan.is_new_color    = out_new_r;
  assign out_chan.color_count     = out_count_r;
  assign out_chan.index_bits      = out_bits_r;
  assign out_chan.too_many_colors = out_ovf_r;
  assign out_chan.image_done      = out_done_r;
endmodule

// ----- src/ipb_cell.sv -----
// One palette slot: holds a colour, compares it with the incoming pixel.
module ipb_cell
  import ipb_pkg::*;
#(
  parameter int SLOT = 0
) (
  input  logic               clk,
  input  logic               cmp_en,
  input  logic [RGB_W-1:0]   cmp_key,
  input  logic               wr_en,
  input  logic [RGB_W-1:0]   wr_key,
  input  logic [COUNT_W-1:0] count,
  input  logic               prev_occ,
  output logic               occ,
  output logic               match_r
);
  localparam logic [COUNT_W-1:0] SLOT_NUM = COUNT_W'(SLOT);

  logic [RGB_W-1:0] color_r;

  // slot in use while below the fill count; passed on to the next cell
  assign occ = (count > SLOT_NUM);

  // first free slot after an occupied neighbour takes the new colour
  always_ff @(posedge clk) begin
    if (wr_en && prev_occ && !occ) begin
      color_r <= wr_key;
    end
  end

  // registered hit flag for the pixel just taken
  always_ff @(posedge clk) begin
    if (cmp_en) begin
      match_r <= occ && (color_r == cmp_key);
    end
  end
endmodule

// ----- src/ipb_encoder.sv -----
// Turns the row's hit flags into a found flag and a slot number.
module ipb_encoder
  import ipb_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int IDX_W = 8
) (
  input  logic [DEPTH-1:0] match,
  output logic             hit,
  output logic [IDX_W-1:0] index
);
  // colours are distinct, so at most one flag is set: OR the slot numbers
  always_comb begin
    index = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (match[i]) begin
        index = index | IDX_W'(i);
      end
    end
  end

  assign hit = |match;
endmodule
